>>> hdl/irppm_pkg.sv
// ----------------------------------------------------------------------------
// irppm_pkg: shared types, tables and microcode for the IR PPM frame encoder
// Word formats, gap tables, the frame prefix and the sequencer program.
// ----------------------------------------------------------------------------
package irppm_pkg;

    // Widths of the word fields
    localparam int BYTE_W   = 8;
    localparam int MARK_W   = 9;
    localparam int SPACE_W  = 15;
    localparam int FRAME_W  = 24;
    localparam int REP_W    = 12;
    localparam int GAP_W    = 12;
    localparam int GT_W     = 16;

    // Configuration register widths
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int GAPUS_W     = 13;
    localparam int TPU_W       = 4;
    localparam int WAKE_W      = 20;
    localparam int WIN_W       = WAKE_W + TPU_W;

    localparam int DURATION_BITS_DEF = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PP16_MODE = 2'd0,
        CFG_GAP_US    = 2'd1,
        CFG_TPU       = 2'd2,
        CFG_WAKE_US   = 2'd3
    } cfg_idx_t;

    // Timing constants
    localparam logic [MARK_W-1:0]  MARK_PP4   = 9'd400;
    localparam logic [MARK_W-1:0]  MARK_PP16  = 9'd210;
    localparam logic [GT_W-1:0]    SPACE_CLIP = 16'd32767;
    localparam logic [GAPUS_W-1:0] MAX_GAP_US = 13'd5000;
    localparam logic [TPU_W-1:0]   MAX_TPU    = 4'd13;
    localparam logic [FRAME_W-1:0] FRAME_MAX  = 24'hFFFFFF;
    localparam logic [REP_W-1:0]   REP_MAX    = 12'd4095;

    // Symbols per byte, as the index of the final symbol
    localparam logic [1:0] SYM4_LAST  = 2'd3;
    localparam logic [1:0] SYM16_LAST = 2'd1;

    // Word formats
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_word_t;

    typedef struct packed {
        logic [MARK_W-1:0]  mark_ticks;
        logic [SPACE_W-1:0] space_ticks;
        logic               last_pulse;
        logic [FRAME_W-1:0] frame_ticks;
        logic [REP_W-1:0]   wake_repeats;
    } out_word_t;

    // PP4 space per 2-bit symbol
    function automatic logic [GAP_W-1:0] gap4(input logic [1:0] sym);
        logic [GAP_W-1:0] g;
        case (sym)
            2'd0:    g = 12'd610;
            2'd1:    g = 12'd2440;
            2'd2:    g = 12'd1220;
            default: g = 12'd1830;
        endcase
        return g;
    endfunction

    // PP16 space per 4-bit symbol
    function automatic logic [GAP_W-1:0] gap16(input logic [3:0] sym);
        logic [GAP_W-1:0] g;
        case (sym)
            4'd0:    g = 12'd270;
            4'd1:    g = 12'd510;
            4'd2:    g = 12'd350;
            4'd3:    g = 12'd430;
            4'd4:    g = 12'd1470;
            4'd5:    g = 12'd1230;
            4'd6:    g = 12'd1390;
            4'd7:    g = 12'd1310;
            4'd8:    g = 12'd830;
            4'd9:    g = 12'd590;
            4'd10:   g = 12'd750;
            4'd11:   g = 12'd670;
            4'd12:   g = 12'd910;
            4'd13:   g = 12'd1150;
            4'd14:   g = 12'd990;
            default: g = 12'd1070;
        endcase
        return g;
    endfunction

    // PP16 frame prefix bytes 00 00 00 40
    function automatic logic [BYTE_W-1:0] lead_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd3:    b = 8'h40;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Microcode
    // ------------------------------------------------------------------------
    localparam int UPC_W = 4;

    typedef enum logic [3:0] {
        OP_ACCEPT,      // take an input word
        OP_LOAD_PRE,    // load next prefix byte into the symbol shifter
        OP_LOAD_DATA,   // load the frame byte into the symbol shifter
        OP_SYM,         // emit one symbol pulse
        OP_NOP,
        OP_GAP_CALC,    // quiet gap in ticks
        OP_SUM_TRAIL,   // add trailer to the duration
        OP_DIV_START,   // start the repeat-count divider
        OP_EMIT_TRAIL,  // emit trailer pulse
        OP_EMIT_REM     // emit mark-less remainder pulse
    } uop_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_PREFIX,
        C_SYM_MORE,
        C_PRE_MORE,
        C_NOT_LAST,
        C_DIV_BUSY,
        C_NO_REM
    } ucond_t;

    typedef struct packed {
        uop_t             op;
        ucond_t           cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    // Program addresses
    localparam logic [UPC_W-1:0] UA_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] UA_PRE      = 4'd1;
    localparam logic [UPC_W-1:0] UA_PRE_SYM  = 4'd2;
    localparam logic [UPC_W-1:0] UA_PRE_NEXT = 4'd3;
    localparam logic [UPC_W-1:0] UA_DATA     = 4'd4;
    localparam logic [UPC_W-1:0] UA_DATA_SYM = 4'd5;
    localparam logic [UPC_W-1:0] UA_END_CHK  = 4'd6;
    localparam logic [UPC_W-1:0] UA_GAP      = 4'd7;
    localparam logic [UPC_W-1:0] UA_SUM      = 4'd8;
    localparam logic [UPC_W-1:0] UA_DIV      = 4'd9;
    localparam logic [UPC_W-1:0] UA_DIV_WAIT = 4'd10;
    localparam logic [UPC_W-1:0] UA_TRAIL    = 4'd11;
    localparam logic [UPC_W-1:0] UA_REM      = 4'd12;

    // Control store: jump to target when cond holds, else fall through
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
        ucode_t w;
        case (pc)
            UA_IDLE:     w = '{OP_ACCEPT,     C_NO_PREFIX, UA_DATA};
            UA_PRE:      w = '{OP_LOAD_PRE,   C_NEVER,     UA_IDLE};
            UA_PRE_SYM:  w = '{OP_SYM,        C_SYM_MORE,  UA_PRE_SYM};
            UA_PRE_NEXT: w = '{OP_NOP,        C_PRE_MORE,  UA_PRE};
            UA_DATA:     w = '{OP_LOAD_DATA,  C_NEVER,     UA_IDLE};
            UA_DATA_SYM: w = '{OP_SYM,        C_SYM_MORE,  UA_DATA_SYM};
            UA_END_CHK:  w = '{OP_NOP,        C_NOT_LAST,  UA_IDLE};
            UA_GAP:      w = '{OP_GAP_CALC,   C_NEVER,     UA_IDLE};
            UA_SUM:      w = '{OP_SUM_TRAIL,  C_NEVER,     UA_IDLE};
            UA_DIV:      w = '{OP_DIV_START,  C_NEVER,     UA_IDLE};
            UA_DIV_WAIT: w = '{OP_NOP,        C_DIV_BUSY,  UA_DIV_WAIT};
            UA_TRAIL:    w = '{OP_EMIT_TRAIL, C_NO_REM,    UA_IDLE};
            UA_REM:      w = '{OP_EMIT_REM,   C_ALWAYS,    UA_IDLE};
            default:     w = '{OP_NOP,        C_ALWAYS,    UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/ir_ppm_frame_encoder.sv
// ----------------------------------------------------------------------------
// ir_ppm_frame_encoder: infrared PP4 / PP16 pulse-position frame encoder
// Per word, one output pulse per symbol step of the microcode sequencer; in
// PP16 a frame's first word is led by the four frame prefix bytes. The final
// word waits on the 24-step repeat-count divider, then emits a trailer pulse,
// plus a remainder pulse if its space is clipped. Output stalls hold the
// sequencer at its emit step. Reset (aresetn low, synchronous) restores
// register defaults and clears the frame state; the first word after reset
// starts a new frame.
module ir_ppm_frame_encoder
    import irppm_pkg::*;
#(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // frame bytes in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_word,
    // pulses out
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_word
);

    localparam int DW    = DURATION_BITS;
    localparam int CMP_W = (DW > FRAME_W) ? DW : FRAME_W;

    // Configuration registers
    logic               mode_reg;
    logic [GAPUS_W-1:0] gap_reg;
    logic [TPU_W-1:0]   tpu_reg;
    logic [WAKE_W-1:0]  wake_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            gap_reg  <= '0;
            tpu_reg  <= TPU_W'(1);
            wake_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PP16_MODE: mode_reg <= cfg_wdata[0];
                CFG_GAP_US:    gap_reg  <= cfg_wdata[GAPUS_W-1:0];
                CFG_TPU:       tpu_reg  <= cfg_wdata[TPU_W-1:0];
                CFG_WAKE_US:   wake_reg <= cfg_wdata[WAKE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped settings and the two small products
    logic [TPU_W-1:0]         tpu_eff;
    logic [GAPUS_W-1:0]       gu_eff;
    logic [GAPUS_W+TPU_W-1:0] gap_prod;
    logic [GT_W-1:0]          gticks_calc;
    logic [WIN_W-1:0]         win;

    always_comb begin
        if (tpu_reg == '0)
            tpu_eff = TPU_W'(1);
        else if (tpu_reg > MAX_TPU)
            tpu_eff = MAX_TPU;
        else
            tpu_eff = tpu_reg;
        gu_eff      = (gap_reg > MAX_GAP_US) ? MAX_GAP_US : gap_reg;
        gap_prod    = (GAPUS_W+TPU_W)'(gu_eff) * (GAPUS_W+TPU_W)'(tpu_eff);
        gticks_calc = (gu_eff == '0) ? GT_W'(1) : gap_prod[GT_W-1:0];
        win         = WIN_W'(wake_reg) * WIN_W'(tpu_eff);
    end

    // Sequencer and datapath state
    logic [UPC_W-1:0]  pc_reg, pc_next;
    logic              inside_reg, inside_next;
    logic [DW-1:0]     sum_reg, sum_next;
    logic [1:0]        pre_cnt_reg, pre_cnt_next;
    logic [1:0]        sym_cnt_reg, sym_cnt_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [BYTE_W-1:0] wrk_reg, wrk_next;
    logic              last_reg, last_next;
    logic              wide_reg, wide_next;
    logic [GT_W-1:0]   gticks_reg, gticks_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_reg, out_next;

    // Divider
    logic             div_start;
    logic             div_busy;
    logic [REP_W-1:0] div_repeats;

    irppm_div #(
        .DURATION_BITS(DURATION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(win),
        .divisor (sum_reg),
        .busy    (div_busy),
        .repeats (div_repeats)
    );

    ucode_t            uw;
    logic              slot_free;
    logic              stall;
    logic              cond_hit;
    logic [MARK_W-1:0] mark;
    logic [GAP_W-1:0]  sym_gap;
    logic [DW:0]       sum_add;
    logic [DW:0]       add_val;
    logic [FRAME_W-1:0] frame_ft;
    logic [SPACE_W-1:0] trail_space;
    logic              trail_last;

    // Step decode, stall and branch condition
    always_comb begin
        uw        = ucode_rom(pc_reg);
        slot_free = !out_valid_reg || m_ready;
        case (uw.op)
            OP_ACCEPT:                          stall = !s_valid;
            OP_SYM, OP_EMIT_TRAIL, OP_EMIT_REM: stall = !slot_free;
            default:                            stall = 1'b0;
        endcase
        case (uw.cond)
            C_ALWAYS:    cond_hit = 1'b1;
            C_NO_PREFIX: cond_hit = inside_reg || !mode_reg;
            C_SYM_MORE:  cond_hit = wide_reg ? (sym_cnt_reg != SYM16_LAST)
                                             : (sym_cnt_reg != SYM4_LAST);
            C_PRE_MORE:  cond_hit = (pre_cnt_reg != '0);
            C_NOT_LAST:  cond_hit = !last_reg;
            C_DIV_BUSY:  cond_hit = div_busy;
            C_NO_REM:    cond_hit = (gticks_reg <= SPACE_CLIP);
            default:     cond_hit = 1'b0;
        endcase
    end

    // Shared datapath terms
    always_comb begin
        mark        = wide_reg ? MARK_PP16 : MARK_PP4;
        sym_gap     = wide_reg ? gap16(wrk_reg[3:0]) : gap4(wrk_reg[1:0]);
        if (uw.op == OP_SYM)
            add_val = (DW+1)'(mark) + (DW+1)'(sym_gap);
        else
            add_val = (DW+1)'(mark) + (DW+1)'(gticks_reg);
        sum_add     = {1'b0, sum_reg} + add_val;
        frame_ft    = (CMP_W'(sum_reg) > CMP_W'(FRAME_MAX)) ? FRAME_MAX
                                                            : FRAME_W'(sum_reg);
        trail_last  = (gticks_reg <= SPACE_CLIP);
        trail_space = trail_last ? gticks_reg[SPACE_W-1:0] : SPACE_CLIP[SPACE_W-1:0];
    end

    // Next-state logic per microcode step
    always_comb begin
        pc_next        = pc_reg;
        inside_next    = inside_reg;
        sum_next       = sum_reg;
        pre_cnt_next   = pre_cnt_reg;
        sym_cnt_next   = sym_cnt_reg;
        byte_next      = byte_reg;
        wrk_next       = wrk_reg;
        last_next      = last_reg;
        wide_next      = wide_reg;
        gticks_next    = gticks_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        div_start      = 1'b0;
        s_ready        = (uw.op == OP_ACCEPT);

        if (!stall) begin
            pc_next = cond_hit ? uw.target : pc_reg + 1'b1;
            case (uw.op)
                OP_ACCEPT: begin
                    byte_next    = s_word.data_byte;
                    last_next    = s_word.last_byte;
                    wide_next    = mode_reg;
                    pre_cnt_next = '0;
                    if (!inside_reg) begin
                        inside_next = 1'b1;
                        sum_next    = '0;
                    end
                end
                OP_LOAD_PRE: begin
                    wrk_next     = lead_byte(pre_cnt_reg);
                    pre_cnt_next = pre_cnt_reg + 1'b1;
                    sym_cnt_next = '0;
                end
                OP_LOAD_DATA: begin
                    wrk_next     = byte_reg;
                    sym_cnt_next = '0;
                end
                OP_SYM: begin
                    out_valid_next = 1'b1;
                    out_next       = '{mark, SPACE_W'(sym_gap), 1'b0, '0, '0};
                    wrk_next       = wide_reg ? (wrk_reg >> 4) : (wrk_reg >> 2);
                    sym_cnt_next   = sym_cnt_reg + 1'b1;
                    sum_next       = sum_add[DW] ? '1 : sum_add[DW-1:0];
                end
                OP_GAP_CALC: begin
                    gticks_next = gticks_calc;
                end
                OP_SUM_TRAIL: begin
                    sum_next = sum_add[DW] ? '1 : sum_add[DW-1:0];
                end
                OP_DIV_START: begin
                    div_start = 1'b1;
                end
                OP_EMIT_TRAIL: begin
                    out_valid_next = 1'b1;
                    if (trail_last) begin
                        out_next    = '{mark, trail_space, 1'b1, frame_ft, div_repeats};
                        inside_next = 1'b0;
                        sum_next    = '0;
                    end else begin
                        out_next = '{mark, trail_space, 1'b0, '0, '0};
                    end
                end
                OP_EMIT_REM: begin
                    out_valid_next = 1'b1;
                    out_next       = '{'0, SPACE_W'(gticks_reg - SPACE_CLIP), 1'b1,
                                       frame_ft, div_repeats};
                    inside_next    = 1'b0;
                    sum_next       = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= UA_IDLE;
            inside_reg    <= 1'b0;
            sum_reg       <= '0;
            pre_cnt_reg   <= '0;
            sym_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            inside_reg    <= inside_next;
            sum_reg       <= sum_next;
            pre_cnt_reg   <= pre_cnt_next;
            sym_cnt_reg   <= sym_cnt_next;
            out_valid_reg <= out_valid_next;
        end
        byte_reg   <= byte_next;
        wrk_reg    <= wrk_next;
        last_reg   <= last_next;
        wide_reg   <= wide_next;
        gticks_reg <= gticks_next;
        out_reg    <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

endmodule

>>> hdl/irppm_div.sv
// ----------------------------------------------------------------------------
// irppm_div: wake repeat-count divider
// Restoring divider, one quotient bit per cycle; gives the rounded-up and
// saturated count of frames that fill the wake window.
// ----------------------------------------------------------------------------
module irppm_div
    import irppm_pkg::*;
#(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [WIN_W-1:0]         dividend,
    input  logic [DURATION_BITS-1:0] divisor,
    output logic                     busy,
    output logic [REP_W-1:0]         repeats
);

    localparam int CNT_W = $clog2(WIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIN_W - 1);

    logic                     busy_reg, busy_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [WIN_W-1:0]         num_reg, num_next;
    logic [DURATION_BITS-1:0] rem_reg, rem_next;
    logic                     zero_reg, zero_next;
    logic [DURATION_BITS:0]   rem_sh;
    logic [DURATION_BITS:0]   rem_sub;
    logic                     ge;

    // One compare-subtract step
    always_comb begin
        rem_sh  = {rem_reg, num_reg[WIN_W-1]};
        rem_sub = rem_sh - {1'b0, divisor};
        ge      = (rem_sh >= {1'b0, divisor});
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        zero_next = zero_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            zero_next = (divisor == '0);
        end else if (busy_reg) begin
            num_next = {num_reg[WIN_W-2:0], ge};
            rem_next = ge ? rem_sub[DURATION_BITS-1:0] : rem_sh[DURATION_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        zero_reg <= zero_next;
    end

    // Ceiling and saturation
    always_comb begin
        if (zero_reg)
            repeats = '0;
        else if (num_reg >= WIN_W'(REP_MAX))
            repeats = REP_MAX;
        else
            repeats = num_reg[REP_W-1:0] + REP_W'(rem_reg != '0);
    end

    assign busy = busy_reg;

endmodule

>>> hdl/irppm_checker.sv
// ----------------------------------------------------------------------------
// irppm_checker: port-level checks for the IR PPM frame encoder
// Watches the result channel and reset; attached to the top level by bind.
// ----------------------------------------------------------------------------
module irppm_checker
    import irppm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // Frame totals appear only on the final pulse
    a_totals: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.last_pulse |->
            m_word.frame_ticks == '0 && m_word.wake_repeats == '0)
        else $error("frame totals on a non-final pulse");

    // Mark is one of the two carrier bursts, or none on a final remainder
    a_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.mark_ticks == MARK_PP4 || m_word.mark_ticks == MARK_PP16
                    || (m_word.mark_ticks == '0 && m_word.last_pulse))
        else $error("unexpected mark length");

    // Every pulse has silence after it
    a_space: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.space_ticks != '0)
        else $error("zero space length");

    // Nothing pending right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ir_ppm_frame_encoder irppm_checker u_irppm_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_word (m_word)
);

>>> bench/ir_ppm_frame_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_ppm_frame_encoder_tb: self-checking bench for the IR PPM frame encoder
// A table of directed frames (both modes, gap and tick-rate extremes, mode
// switches inside a frame) is followed by random frames in phases with new
// register settings. Every accepted frame byte is run through a local pulse
// encoder, and each pulse word leaving the block is checked against it.
// ----------------------------------------------------------------------------
module ir_ppm_frame_encoder_tb;
    import irppm_pkg::*;

    // Pulse timing in ticks, register limits and bench settings
    localparam int     MARK4_TICKS      = 400;
    localparam int     MARK16_TICKS     = 210;
    localparam int     SPACE_MAX        = 32767;
    localparam int     GAP_US_MAX       = 5000;
    localparam int     TPU_MAX          = 13;
    localparam longint DUR_LIMIT        = (64'd1 << DURATION_BITS_DEF) - 1;
    localparam longint FRAME_TICKS_MAX  = 64'hFFFFFF;
    localparam longint REPEATS_MAX      = 4095;
    localparam int     SETTLE_CYCLES    = 64;
    localparam int     HOLD_CYCLES      = 400;
    localparam int     PHASES           = 6;
    localparam int     WORDS_PER_PHASE  = 42;

    localparam logic MODE_PP4  = 1'b0;
    localparam logic MODE_PP16 = 1'b1;

    localparam int GAP4_TICKS [0:3] = '{610, 2440, 1220, 1830};
    localparam int GAP16_TICKS [0:15] = '{270, 510, 350, 430, 1470, 1230, 1390, 1310,
                                          830, 590, 750, 670, 910, 1150, 990, 1070};
    localparam logic [7:0] LEAD_SEQ [0:3] = '{8'h00, 8'h00, 8'h00, 8'h40};

    // One directed step: register settings, the byte, and optional known totals
    typedef struct packed {
        logic        mode;
        logic [12:0] gap;
        logic [3:0]  tpu;
        logic [19:0] wake;
        logic [7:0]  data;
        logic        last;
        logic        known;
        logic [23:0] frame_ticks;
        logic [11:0] repeats;
    } frame_step_t;

    localparam int N_STEPS = 22;
    localparam frame_step_t FRAME_STEPS [0:N_STEPS-1] = '{
        // reset settings, PP4 single-byte frames
        '{MODE_PP4,  13'd0,    4'd0 + 4'd1, 20'd0,       8'h00, 1'b1, 1'b1, 24'd4441,  12'd0},
        '{MODE_PP4,  13'd0,    4'd1,  20'd0,       8'hFF, 1'b1, 1'b1, 24'd9321,  12'd0},
        '{MODE_PP4,  13'd0,    4'd1,  20'd0,       8'hE4, 1'b1, 1'b1, 24'd8101,  12'd0},
        // PP16 with prefix, then every nibble value across one frame
        '{MODE_PP16, 13'd0,    4'd1,  20'd0,       8'h00, 1'b1, 1'b1, 24'd6211,  12'd0},
        '{MODE_PP16, 13'd0,    4'd1,  20'd0,       8'h10, 1'b0, 1'b0, 24'd0,     12'd0},
        '{MODE_PP16, 13'd0,    4'd1,  20'd0,       8'h32, 1'b0, 1'b0, 24'd0,     12'd0},
        '{MODE_PP16, 13'd0,    4'd1,  20'd0,       8'h54, 1'b0, 1'b0, 24'd0,     12'd0},
        '{MODE_PP16, 13'd0,    4'd1,  20'd0,       8'h76, 1'b0, 1'b0, 24'd0,     12'd0},
        '{MODE_PP16, 13'd0,    4'd1,  20'd0,       8'h98, 1'b0, 1'b0, 24'd0,     12'd0},
        '{MODE_PP16, 13'd0,    4'd1,  20'd0,       8'hBA, 1'b0, 1'b0, 24'd0,     12'd0},
        '{MODE_PP16, 13'd0,    4'd1,  20'd0,       8'hDC, 1'b0, 1'b0, 24'd0,     12'd0},
        '{MODE_PP16, 13'd0,    4'd1,  20'd0,       8'hFE, 1'b1, 1'b0, 24'd0,     12'd0},
        // longest gap, remainder pulse; then gap and tick rate above range
        '{MODE_PP4,  13'd5000, 4'd13, 20'd1000000, 8'hFF, 1'b1, 1'b1, 24'd74320, 12'd175},
        '{MODE_PP4,  13'h1FFF, 4'd15, 20'hFFFFF,   8'h00, 1'b1, 1'b1, 24'd69440, 12'd197},
        // tick rate zero
        '{MODE_PP4,  13'd100,  4'd0,  20'd1000,    8'h5A, 1'b1, 1'b0, 24'd0,     12'd0},
        // trailer space just under and just over the clip
        '{MODE_PP16, 13'd2520, 4'd13, 20'd0,       8'h40, 1'b1, 1'b0, 24'd0,     12'd0},
        '{MODE_PP16, 13'd2521, 4'd13, 20'd0,       8'hC3, 1'b1, 1'b0, 24'd0,     12'd0},
        // mode switched inside a frame, both directions
        '{MODE_PP16, 13'd7,    4'd2,  20'd500000,  8'h11, 1'b0, 1'b0, 24'd0,     12'd0},
        '{MODE_PP4,  13'd7,    4'd2,  20'd500000,  8'hAA, 1'b1, 1'b0, 24'd0,     12'd0},
        '{MODE_PP4,  13'd7,    4'd2,  20'd500000,  8'h5F, 1'b0, 1'b0, 24'd0,     12'd0},
        '{MODE_PP16, 13'd7,    4'd2,  20'd500000,  8'hA0, 1'b1, 1'b0, 24'd0,     12'd0},
        // one-microsecond gap, tiny wake window
        '{MODE_PP4,  13'd1,    4'd13, 20'd1,       8'h81, 1'b1, 1'b0, 24'd0,     12'd0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PP16_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_word = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_word;

    // Local copy of the registers and the frame state
    logic   cur_pp16 = MODE_PP4;
    int     cur_gap = 0;
    int     cur_tpu = 1;
    int     cur_wake = 0;
    bit     frame_open = 1'b0;
    longint frame_dur = 0;

    out_word_t pulses_pending [$];
    int        mismatch_count = 0;
    int        src_idle_pct = 8;
    int        dst_idle_pct = 81;
    int        hold_reqs = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    out_word_t want;

    ir_ppm_frame_encoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("** ir_ppm_frame_encoder: FAILED **");
        $finish;
    end

    function automatic out_word_t make_pulse(input int mark, input int space);
        out_word_t p;
        p = '0;
        p.mark_ticks  = mark[MARK_W-1:0];
        p.space_ticks = space[SPACE_W-1:0];
        return p;
    endfunction

    task automatic add_dur(input longint t);
        frame_dur = frame_dur + t;
        if (frame_dur > DUR_LIMIT) frame_dur = DUR_LIMIT;
    endtask

    // One pulse per symbol, least significant symbol first
    task automatic encode_symbols(input logic [7:0] b, input bit wide);
        int sh;
        int g;
        if (wide) begin
            for (sh = 0; sh < 8; sh += 4) begin
                g = GAP16_TICKS[(b >> sh) & 8'hF];
                pulses_pending.push_back(make_pulse(MARK16_TICKS, g));
                add_dur(MARK16_TICKS + g);
            end
        end else begin
            for (sh = 0; sh < 8; sh += 2) begin
                g = GAP4_TICKS[(b >> sh) & 8'h3];
                pulses_pending.push_back(make_pulse(MARK4_TICKS, g));
                add_dur(MARK4_TICKS + g);
            end
        end
    endtask

    // Expected pulses for one frame byte, trailer and totals on the last one
    task automatic encode_frame_byte(input logic [7:0] d, input logic last);
        bit        wide;
        int        mark;
        int        gu;
        int        tpu;
        int        gticks;
        int        first;
        longint    win;
        longint    rep;
        out_word_t tail;
        wide = (cur_pp16 == MODE_PP16);
        mark = wide ? MARK16_TICKS : MARK4_TICKS;
        if (!frame_open) begin
            frame_open = 1'b1;
            frame_dur  = 0;
            if (wide)
                for (int i = 0; i < 4; i++) encode_symbols(LEAD_SEQ[i], 1'b1);
        end
        encode_symbols(d, wide);
        if (last) begin
            gu     = (cur_gap > GAP_US_MAX) ? GAP_US_MAX : cur_gap;
            tpu    = (cur_tpu == 0) ? 1 : ((cur_tpu > TPU_MAX) ? TPU_MAX : cur_tpu);
            gticks = (gu == 0) ? 1 : gu * tpu;
            first  = (gticks > SPACE_MAX) ? SPACE_MAX : gticks;
            pulses_pending.push_back(make_pulse(mark, first));
            if (gticks > first) pulses_pending.push_back(make_pulse(0, gticks - first));
            add_dur(mark + gticks);
            win = longint'(cur_wake) * tpu;
            rep = (frame_dur == 0) ? 0 : (win + frame_dur - 1) / frame_dur;
            if (rep > REPEATS_MAX) rep = REPEATS_MAX;
            tail = pulses_pending.pop_back();
            tail.last_pulse   = 1'b1;
            tail.frame_ticks  = (frame_dur > FRAME_TICKS_MAX) ? FRAME_TICKS_MAX[23:0]
                                                              : frame_dur[23:0];
            tail.wake_repeats = rep[REP_W-1:0];
            pulses_pending.push_back(tail);
            frame_open = 1'b0;
            frame_dur  = 0;
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_PP16_MODE: cur_pp16 = val[0];
            CFG_GAP_US:    cur_gap  = val & 32'h1FFF;
            CFG_TPU:       cur_tpu  = val & 32'hF;
            CFG_WAKE_US:   cur_wake = val & 32'hFFFFF;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_cfg(input logic mode, input int gap, input int tpu, input int wake);
        write_reg(CFG_PP16_MODE, int'(mode));
        write_reg(CFG_GAP_US, gap);
        write_reg(CFG_TPU, tpu);
        write_reg(CFG_WAKE_US, wake);
        cfg_wr_en <= 1'b0;
    endtask

    // Stop offering words and let the block run dry
    task automatic settle();
        s_valid <= 1'b0;
        while (pulses_pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Offer one frame byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] d, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_word.data_byte <= d;
        s_word.last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        encode_frame_byte(d, last);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Pulse word checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pulses_pending.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected pulse mark=%0d space=%0d last=%0d ft=%0d rep=%0d",
                             $realtime, m_word.mark_ticks, m_word.space_ticks,
                             m_word.last_pulse, m_word.frame_ticks, m_word.wake_repeats);
            end else begin
                want = pulses_pending.pop_front();
                if (m_word.mark_ticks !== want.mark_ticks
                        || m_word.space_ticks !== want.space_ticks
                        || m_word.last_pulse !== want.last_pulse
                        || m_word.frame_ticks !== want.frame_ticks
                        || m_word.wake_repeats !== want.wake_repeats) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: pulse mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 $realtime, want.mark_ticks, want.space_ticks,
                                 want.last_pulse, want.frame_ticks, want.wake_repeats,
                                 m_word.mark_ticks, m_word.space_ticks,
                                 m_word.last_pulse, m_word.frame_ticks, m_word.wake_repeats);
                end
            end
        end
    end

    initial begin
        frame_step_t step;
        out_word_t   tail;
        int          bytes_left;
        int          gap;
        logic        last;

        bytes_left = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames; registers rewritten only when a step changes them
        for (int r = 0; r < N_STEPS; r++) begin
            step = FRAME_STEPS[r];
            if (step.mode != cur_pp16 || int'(step.gap) != cur_gap
                    || int'(step.tpu) != cur_tpu || int'(step.wake) != cur_wake) begin
                settle();
                apply_cfg(step.mode, int'(step.gap), int'(step.tpu), int'(step.wake));
            end
            send_byte(step.data, step.last);
            if (step.known) begin
                tail = pulses_pending.pop_back();
                tail.frame_ticks  = step.frame_ticks;
                tail.wake_repeats = step.repeats;
                pulses_pending.push_back(tail);
            end
        end

        // Random frames; a phase boundary may fall inside a frame
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph / 2)
                0: begin src_idle_pct = 8;  dst_idle_pct = 81; end
                1: begin src_idle_pct = 81; dst_idle_pct = 8;  end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            case ($urandom_range(3))
                0: gap = $urandom_range(0, 8191);
                1: gap = $urandom_range(0, 300);
                2: gap = GAP_US_MAX;
                default: gap = 2521;
            endcase
            if (ph == 1)
                apply_cfg(MODE_PP16, 8191, 15, 20'hFFFFF);
            else if (ph == 2)
                apply_cfg(MODE_PP4, 0, 0, 0);
            else
                apply_cfg(logic'($urandom_range(1)), gap, $urandom_range(0, 15),
                          $urandom_range(0, 20'hFFFFF));
            // long receiver stall while words keep coming
            if (ph == 4) hold_reqs <= hold_reqs + 1;
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if (bytes_left == 0)
                    bytes_left = ($urandom_range(99) < 70) ? $urandom_range(1, 3)
                                                           : $urandom_range(4, 12);
                last = (bytes_left == 1);
                bytes_left--;
                send_byte(8'($urandom_range(0, 255)), last);
            end
        end

        settle();
        if (mismatch_count == 0 && pulses_pending.size() == 0) begin
            $display("** ir_ppm_frame_encoder: PASSED **");
        end else begin
            $display("** ir_ppm_frame_encoder: FAILED **");
        end
        $finish;
    end

endmodule
